### rtl/cds_pkg.sv
// Coin dispense supervisor package: word types, phase encoding, register
// indexes, finish reason codes and fixed timing constants.
// No dependencies.
package cds_pkg;

	// Field widths
	localparam int unsigned TIMEOUT_W = 22;
	localparam int unsigned MSPC_W    = 14;
	localparam int unsigned RETRY_W   = 4;
	localparam int unsigned TICK16_W  = 16;
	localparam int unsigned COIN_W    = 8;
	localparam int unsigned PULSE_W   = 16;
	localparam int unsigned PHTMR_W   = 17;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 22;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_HARD_TIMEOUT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MS_PER_COIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE_MS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_JAM_MS       = 3'd4;

	// Register reset values
	localparam logic [TIMEOUT_W-1:0] HARD_TIMEOUT_RST = 22'd10000;
	localparam logic [MSPC_W-1:0]    MS_PER_COIN_RST  = 14'd1000;
	localparam logic [RETRY_W-1:0]   MAX_RETRIES_RST  = 4'd2;
	localparam logic [TICK16_W-1:0]  SETTLE_MS_RST    = 16'd100;
	localparam logic [TICK16_W-1:0]  JAM_MS_RST       = 16'd1500;

	// Fixed timing
	localparam logic [TIMEOUT_W:0]   BUDGET_EXTRA_MS = 23'd500;
	localparam logic [PHTMR_W-1:0]   BACKOFF_MS      = 17'd100;

	// Command codes
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	// Finish reasons
	localparam logic [1:0] REASON_OK      = 2'd0;
	localparam logic [1:0] REASON_JAM     = 2'd1;
	localparam logic [1:0] REASON_PARTIAL = 2'd2;
	localparam logic [1:0] REASON_TIMEOUT = 2'd3;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_SETTLE  = 2'd1,
		PH_RUN     = 2'd2,
		PH_BACKOFF = 2'd3
	} phase_t;

	typedef struct packed {
		logic               cmd;
		logic [COIN_W-1:0]  coins;
		logic [PULSE_W-1:0] pulse_count;
		logic [COIN_W-1:0]  coin_count;
	} in_word_t;

	typedef struct packed {
		logic                 motor_on;
		logic                 clear_counters;
		logic                 busy_res;
		logic                 done_res;
		logic                 success;
		logic [1:0]           reason;
		logic [COIN_W-1:0]    dispensed;
		logic [PULSE_W-1:0]   pulses;
		logic [RETRY_W-1:0]   retries;
		logic [TIMEOUT_W-1:0] elapsed_ticks;
	} out_word_t;

endpackage

### rtl/coin_dispense_supervisor_core.sv
// Coin dispense supervisor top level: input register, phase sequencer with
// its timers, result register and configuration registers.
// Depends on cds_pkg.

// Takes one word per clock cycle on the input channel while the output side is
// not stalled and gives exactly one result word for each. A word is held in the
// input register, and its result is loaded into the output register when that
// register is free or draining; throughput is one word per cycle while the
// output side is not stalled. The per-word path is one 8x14 multiply for
// the time budget plus the timer increments and compares of the sequencer.
// Configuration writes take effect on the next edge and are meant for idle.
module coin_dispense_supervisor_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [cds_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [cds_pkg::CFG_DAT_W-1:0]        cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  cds_pkg::in_word_t                    in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output cds_pkg::out_word_t                   out_data
);

	localparam logic [cds_pkg::TIMEOUT_W-1:0] ELAPSED_MAX = '1;
	localparam logic [cds_pkg::TICK16_W-1:0]  QUIET_MAX   = '1;
	localparam logic [cds_pkg::PHTMR_W-1:0]   PHTMR_MAX   = '1;

	// Configuration registers
	logic [cds_pkg::TIMEOUT_W-1:0] hard_timeout_q;
	logic [cds_pkg::MSPC_W-1:0]    ms_per_coin_q;
	logic [cds_pkg::RETRY_W-1:0]   max_retries_q;
	logic [cds_pkg::TICK16_W-1:0]  settle_ms_q;
	logic [cds_pkg::TICK16_W-1:0]  jam_ms_q;

	// Sequencer state
	cds_pkg::phase_t               phase_q, phase_d;
	logic [cds_pkg::COIN_W-1:0]    requested_q, requested_d;
	logic [cds_pkg::RETRY_W-1:0]   attempt_q, attempt_d;
	logic [cds_pkg::PHTMR_W-1:0]   phase_timer_q, phase_timer_d;
	logic [cds_pkg::TICK16_W-1:0]  quiet_q, quiet_d;
	logic [cds_pkg::TIMEOUT_W-1:0] elapsed_q, elapsed_d;
	logic [cds_pkg::TIMEOUT_W-1:0] budget_q, budget_d;
	logic [cds_pkg::PULSE_W-1:0]   last_pulses_q, last_pulses_d;

	// Pipeline registers
	logic                          valid_s1;
	cds_pkg::in_word_t             word_s1;
	logic                          out_valid_q;
	cds_pkg::out_word_t            out_word_q, res;

	logic advance;

	// Advance the input register when the result slot is free or draining
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_word_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hard_timeout_q <= cds_pkg::HARD_TIMEOUT_RST;
			ms_per_coin_q  <= cds_pkg::MS_PER_COIN_RST;
			max_retries_q  <= cds_pkg::MAX_RETRIES_RST;
			settle_ms_q    <= cds_pkg::SETTLE_MS_RST;
			jam_ms_q       <= cds_pkg::JAM_MS_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				cds_pkg::REG_HARD_TIMEOUT: hard_timeout_q <= cfg_data;
				cds_pkg::REG_MS_PER_COIN:  ms_per_coin_q  <= cfg_data[cds_pkg::MSPC_W-1:0];
				cds_pkg::REG_MAX_RETRIES:  max_retries_q  <= cfg_data[cds_pkg::RETRY_W-1:0];
				cds_pkg::REG_SETTLE_MS:    settle_ms_q    <= cfg_data[cds_pkg::TICK16_W-1:0];
				cds_pkg::REG_JAM_MS:       jam_ms_q       <= cfg_data[cds_pkg::TICK16_W-1:0];
				default: ;
			endcase
		end
	end

	// Budget for a start word: max(hard timeout, coins*ms_per_coin + 500), saturated
	logic [cds_pkg::TIMEOUT_W-1:0] coin_prod;
	logic [cds_pkg::TIMEOUT_W:0]   budget_sum;
	logic [cds_pkg::TIMEOUT_W-1:0] budget_new;

	assign coin_prod  = cds_pkg::TIMEOUT_W'(word_s1.coins)
	                  * cds_pkg::TIMEOUT_W'(ms_per_coin_q);
	assign budget_sum = {1'b0, coin_prod} + cds_pkg::BUDGET_EXTRA_MS;

	always_comb begin
		if (budget_sum < {1'b0, hard_timeout_q}) begin
			budget_new = hard_timeout_q;
		end else if (budget_sum[cds_pkg::TIMEOUT_W]) begin
			budget_new = ELAPSED_MAX;
		end else begin
			budget_new = budget_sum[cds_pkg::TIMEOUT_W-1:0];
		end
	end

	// Shared timer increments and run checks
	logic                          is_start;
	logic [cds_pkg::TIMEOUT_W-1:0] elapsed_inc;
	logic [cds_pkg::PHTMR_W-1:0]   phase_timer_inc;
	logic [cds_pkg::TICK16_W-1:0]  quiet_eff;
	logic                          pulse_moved;
	logic                          settle_done, backoff_done, do_checks;
	logic                          coins_ok, jammed, can_retry, over_budget;

	assign is_start        = (word_s1.cmd == cds_pkg::CMD_START);
	assign elapsed_inc     = (elapsed_q != ELAPSED_MAX) ? elapsed_q + 1'b1 : elapsed_q;
	assign phase_timer_inc = (phase_timer_q != PHTMR_MAX) ? phase_timer_q + 1'b1
	                                                      : phase_timer_q;
	assign settle_done     = (phase_timer_inc >= {1'b0, settle_ms_q});
	assign backoff_done    = (phase_timer_inc >= cds_pkg::BACKOFF_MS);
	assign pulse_moved     = (word_s1.pulse_count != last_pulses_q);
	assign do_checks       = (phase_q == cds_pkg::PH_RUN)
	                      || (phase_q == cds_pkg::PH_SETTLE && settle_done);

	// Quiet time as seen by the checks: zero on run entry or pulse movement
	always_comb begin
		if (phase_q == cds_pkg::PH_SETTLE || pulse_moved) begin
			quiet_eff = '0;
		end else if (quiet_q != QUIET_MAX) begin
			quiet_eff = quiet_q + 1'b1;
		end else begin
			quiet_eff = quiet_q;
		end
	end

	assign coins_ok    = (word_s1.coin_count >= requested_q);
	assign jammed      = (quiet_eff >= jam_ms_q);
	assign can_retry   = (attempt_q < max_retries_q);
	assign over_budget = (elapsed_inc >= budget_q);

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (is_start) begin
			phase_d = cds_pkg::PH_SETTLE;
		end else begin
			unique case (phase_q)
				cds_pkg::PH_IDLE: phase_d = cds_pkg::PH_IDLE;
				cds_pkg::PH_BACKOFF: begin
					if (backoff_done) phase_d = cds_pkg::PH_SETTLE;
				end
				cds_pkg::PH_SETTLE, cds_pkg::PH_RUN: begin
					if (do_checks) begin
						priority if (coins_ok) begin
							phase_d = cds_pkg::PH_IDLE;
						end else if (jammed) begin
							phase_d = can_retry ? cds_pkg::PH_BACKOFF : cds_pkg::PH_IDLE;
						end else if (over_budget) begin
							phase_d = cds_pkg::PH_IDLE;
						end else begin
							phase_d = cds_pkg::PH_RUN;
						end
					end
				end
				default: phase_d = cds_pkg::PH_IDLE;
			endcase
		end
	end

	// Datapath updates and result word
	always_comb begin
		requested_d   = requested_q;
		attempt_d     = attempt_q;
		phase_timer_d = phase_timer_q;
		quiet_d       = quiet_q;
		elapsed_d     = elapsed_q;
		budget_d      = budget_q;
		last_pulses_d = last_pulses_q;
		res           = '0;

		if (is_start) begin
			budget_d           = budget_new;
			requested_d        = word_s1.coins;
			attempt_d          = '0;
			elapsed_d          = '0;
			phase_timer_d      = '0;
			quiet_d            = '0;
			last_pulses_d      = '0;
			res.motor_on       = 1'b1;
			res.clear_counters = 1'b1;
			res.busy_res       = 1'b1;
		end else if (phase_q != cds_pkg::PH_IDLE) begin
			elapsed_d = elapsed_inc;
			if (phase_q == cds_pkg::PH_BACKOFF) begin
				res.busy_res = 1'b1;
				if (backoff_done) begin
					attempt_d          = attempt_q + 1'b1;
					phase_timer_d      = '0;
					res.motor_on       = 1'b1;
					res.clear_counters = 1'b1;
				end else begin
					phase_timer_d = phase_timer_inc;
				end
			end else if (!do_checks) begin
				// Still settling
				phase_timer_d = phase_timer_inc;
				res.motor_on  = 1'b1;
				res.busy_res  = 1'b1;
			end else begin
				if (phase_q == cds_pkg::PH_SETTLE) begin
					phase_timer_d = phase_timer_inc;
					last_pulses_d = word_s1.pulse_count;
				end else if (pulse_moved) begin
					last_pulses_d = word_s1.pulse_count;
				end
				quiet_d = quiet_eff;

				// Finish fields, qualified by done_res below
				res.dispensed     = word_s1.coin_count;
				res.pulses        = word_s1.pulse_count;
				res.retries       = attempt_q;
				res.elapsed_ticks = elapsed_inc;

				priority if (coins_ok) begin
					res.done_res = 1'b1;
					res.success  = 1'b1;
					res.reason   = cds_pkg::REASON_OK;
				end else if (jammed && can_retry) begin
					phase_timer_d = '0;
					res.busy_res  = 1'b1;
				end else if (jammed) begin
					res.done_res = 1'b1;
					res.reason   = (word_s1.coin_count != '0) ? cds_pkg::REASON_PARTIAL
					                                          : cds_pkg::REASON_JAM;
				end else if (over_budget) begin
					res.done_res = 1'b1;
					res.reason   = (word_s1.coin_count != '0) ? cds_pkg::REASON_PARTIAL
					                                          : cds_pkg::REASON_TIMEOUT;
				end else begin
					res.motor_on = 1'b1;
					res.busy_res = 1'b1;
				end

				// Drop finish fields when not finished
				if (!res.done_res) begin
					res.dispensed     = '0;
					res.pulses        = '0;
					res.retries       = '0;
					res.elapsed_ticks = '0;
				end
			end
		end
	end

	// Hold the input word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			word_s1 <= in_data;
		end
	end

	// Advance sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= cds_pkg::PH_IDLE;
			requested_q   <= '0;
			attempt_q     <= '0;
			phase_timer_q <= '0;
			quiet_q       <= '0;
			elapsed_q     <= '0;
			budget_q      <= '0;
			last_pulses_q <= '0;
		end else if (advance) begin
			phase_q       <= phase_d;
			requested_q   <= requested_d;
			attempt_q     <= attempt_d;
			phase_timer_q <= phase_timer_d;
			quiet_q       <= quiet_d;
			elapsed_q     <= elapsed_d;
			budget_q      <= budget_d;
			last_pulses_q <= last_pulses_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_word_q <= res;
		end
	end

endmodule
